[design/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, types and cofactor index tables for the 3x3 inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

    // element format: signed q8.8
    localparam int ELEM_W    = 16;
    localparam int FRAC_BITS = 8;

    // product, cofactor and determinant widths
    localparam int PROD_W = 2 * ELEM_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int DET_W  = ELEM_W + COF_W;

    // divider: dividend is |cofactor| scaled by 2^(2*frac)
    localparam int SCALE_W = 2 * FRAC_BITS;
    localparam int NUM_W   = COF_W + SCALE_W;
    localparam int MAG_W   = (NUM_W > DET_W) ? NUM_W : DET_W;
    localparam int STEPS   = ELEM_W;
    localparam int EXT_W   = MAG_W + STEPS + 1;

    // latencies in register stages
    localparam int DET_LAT = 4;
    localparam int DIV_LAT = STEPS + 3;
    localparam int TOT_LAT = DET_LAT + DIV_LAT;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic        [MAG_W-1:0]  t_mag;

    // cofactor i = m[A]*m[B] - m[C]*m[D], already transposed (adjugate order)
    localparam logic [3:0] COF_A [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_B [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_C [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_D [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

`default_nettype wire

[design/mi3_in_if.sv]
// ----------------------------------------------------------------------------
// mi3_in_if
// Input channel: one 3x3 q8.8 matrix per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi3_in_if
    import mi3_pkg::*;
();
    logic  valid;
    logic  ready;
    t_elem in_r0c0;
    t_elem in_r0c1;
    t_elem in_r0c2;
    t_elem in_r1c0;
    t_elem in_r1c1;
    t_elem in_r1c2;
    t_elem in_r2c0;
    t_elem in_r2c1;
    t_elem in_r2c2;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        output ready
    );
endinterface

`default_nettype wire

[design/mi3_out_if.sv]
// ----------------------------------------------------------------------------
// mi3_out_if
// Output channel: inverse matrix, determinant and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi3_out_if
    import mi3_pkg::*;
();
    logic  valid;
    logic  ready;
    t_elem inv_r0c0;
    t_elem inv_r0c1;
    t_elem inv_r0c2;
    t_elem inv_r1c0;
    t_elem inv_r1c1;
    t_elem inv_r1c2;
    t_elem inv_r2c0;
    t_elem inv_r2c1;
    t_elem inv_r2c2;
    t_det  det_value;
    logic  singular_flag;
    logic  saturated_flag;

    modport source (
        output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, det_value, singular_flag,
               saturated_flag,
        input  ready
    );
    modport sink (
        input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, det_value, singular_flag,
               saturated_flag,
        output ready
    );
endinterface

`default_nettype wire

[design/matrix3x3_inverse_core.sv]
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Fixed-point 3x3 inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Takes one q8.8 matrix per cycle and returns its inverse in q8.8 (each
// element truncated toward zero and clamped, with a saturation flag), the exact
// determinant with 24 fractional bits, and a singular flag (all-zero inverse)
// when the determinant is zero. The determinant pipeline feeds the nine
// parallel divider lanes, which produce one quotient bit per stage.
// Throughput is one transaction per cycle; the whole pipeline holds when the
// output transaction is not taken.
`default_nettype none

module matrix3x3_inverse_core
    import mi3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mi3_in_if.sink     i_in,
    mi3_out_if.source  o_out
);

    logic  en;
    t_elem m [9];
    t_cof  cof [9];
    t_det  det;
    t_elem q [9];
    logic  sat [9];
    logic  any_sat;
    logic  sing;

    logic  r_vld [TOT_LAT];
    t_det  r_det_dly [DIV_LAT];

    // pipeline advances unless the last stage holds an untaken result
    assign en         = !r_vld[TOT_LAT-1] || o_out.ready;
    assign i_in.ready = en;

    assign m[0] = i_in.in_r0c0;
    assign m[1] = i_in.in_r0c1;
    assign m[2] = i_in.in_r0c2;
    assign m[3] = i_in.in_r1c0;
    assign m[4] = i_in.in_r1c1;
    assign m[5] = i_in.in_r1c2;
    assign m[6] = i_in.in_r2c0;
    assign m[7] = i_in.in_r2c1;
    assign m[8] = i_in.in_r2c2;

    mi3_det u_det (
        .i_clk (i_clk),
        .i_en  (en),
        .i_m   (m),
        .o_cof (cof),
        .o_det (det)
    );

    for (genvar i = 0; i < 9; i++) begin : g_lane
        mi3_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_cof (cof[i]),
            .i_det (det),
            .o_q   (q[i]),
            .o_sat (sat[i])
        );
    end

    // valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < TOT_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // determinant delay matching the divider lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det_dly[0] <= det;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_det_dly[k] <= r_det_dly[k-1];
            end
        end
    end

    // singular override and flag merge
    always_comb begin
        any_sat = 1'b0;
        for (int i = 0; i < 9; i++) begin
            any_sat = any_sat | sat[i];
        end
    end

    assign sing = (r_det_dly[DIV_LAT-1] == '0);

    assign o_out.valid          = r_vld[TOT_LAT-1];
    assign o_out.inv_r0c0       = sing ? '0 : q[0];
    assign o_out.inv_r0c1       = sing ? '0 : q[1];
    assign o_out.inv_r0c2       = sing ? '0 : q[2];
    assign o_out.inv_r1c0       = sing ? '0 : q[3];
    assign o_out.inv_r1c1       = sing ? '0 : q[4];
    assign o_out.inv_r1c2       = sing ? '0 : q[5];
    assign o_out.inv_r2c0       = sing ? '0 : q[6];
    assign o_out.inv_r2c1       = sing ? '0 : q[7];
    assign o_out.inv_r2c2       = sing ? '0 : q[8];
    assign o_out.det_value      = r_det_dly[DIV_LAT-1];
    assign o_out.singular_flag  = sing;
    assign o_out.saturated_flag = !sing && any_sat;

endmodule

`default_nettype wire

[design/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det
// Four-stage pipeline: minor products, cofactors, row-0 products, determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_det
    import mi3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_elem i_m   [9],
    output t_cof       o_cof [9],
    output t_det       o_det
);

    t_prod r_pa  [9];
    t_prod r_pb  [9];
    t_cof  r_cof [9];
    t_cof  r_cof3[9];
    t_elem r_m1  [3];
    t_elem r_m2  [3];
    t_det  r_dp  [3];
    t_cof  r_cof4[9];
    t_det  r_det;

    // stage 1: the eighteen 2x2 minor products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_pa[i] <= PROD_W'(i_m[COF_A[i]]) * PROD_W'(i_m[COF_B[i]]);
                r_pb[i] <= PROD_W'(i_m[COF_C[i]]) * PROD_W'(i_m[COF_D[i]]);
            end
            for (int j = 0; j < 3; j++) begin
                r_m1[j] <= i_m[j];
            end
        end
    end

    // stage 2: cofactors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_cof[i] <= COF_W'(r_pa[i]) - COF_W'(r_pb[i]);
            end
            r_m2 <= r_m1;
        end
    end

    // stage 3: first-row element times its cofactor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp[0] <= DET_W'(r_m2[0]) * DET_W'(r_cof[0]);
            r_dp[1] <= DET_W'(r_m2[1]) * DET_W'(r_cof[3]);
            r_dp[2] <= DET_W'(r_m2[2]) * DET_W'(r_cof[6]);
            r_cof3  <= r_cof;
        end
    end

    // stage 4: determinant sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det  <= r_dp[0] + r_dp[1] + r_dp[2];
            r_cof4 <= r_cof3;
        end
    end

    assign o_cof = r_cof4;
    assign o_det = r_det;

endmodule

`default_nettype wire

[design/mi3_div.sv]
// ----------------------------------------------------------------------------
// mi3_div
// One divider lane: sign/magnitude split, overflow check, one quotient bit
// per stage (restoring), then sign restore and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div
    import mi3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_cof  i_cof,
    input  wire t_det  i_det,
    output t_elem      o_q,
    output logic       o_sat
);

    localparam logic [ELEM_W-1:0] POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] NEG_MAX = {1'b1, {(ELEM_W-1){1'b0}}};

    t_mag              r_nmag;
    t_mag              r_dmag;
    logic              r_neg;
    t_mag              r_nmag_b;
    t_mag              r_dmag_b;
    logic              r_neg_b;
    logic              r_ovf_b;
    t_mag              r_rem [STEPS];
    t_mag              r_dm  [STEPS];
    logic [STEPS-1:0]  r_q   [STEPS];
    logic              r_ng  [STEPS];
    logic              r_ov  [STEPS];
    t_elem             r_out;
    logic              r_sat;

    logic [COF_W-1:0]  cof_abs;
    logic [DET_W-1:0]  det_abs;

    // magnitudes of the scaled dividend and divisor
    assign cof_abs = i_cof[COF_W-1] ? COF_W'(-i_cof) : COF_W'(i_cof);
    assign det_abs = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmag <= MAG_W'({cof_abs, {SCALE_W{1'b0}}});
            r_dmag <= MAG_W'(det_abs);
            r_neg  <= i_cof[COF_W-1] ^ i_det[DET_W-1];
        end
    end

    // quotient of 2^steps or more always saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf_b  <= EXT_W'(r_nmag) >= (EXT_W'(r_dmag) << STEPS);
            r_nmag_b <= r_nmag;
            r_dmag_b <= r_dmag;
            r_neg_b  <= r_neg;
        end
    end

    // restoring steps, msb first
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int K = STEPS - 1 - s;
        t_mag             rem_in;
        t_mag             dm_in;
        logic [STEPS-1:0] q_in;
        logic             ng_in;
        logic             ov_in;
        logic [EXT_W-1:0] trial;
        logic             ge;
        logic [STEPS-1:0] q_nx;

        if (s == 0) begin : g_first
            assign rem_in = r_nmag_b;
            assign dm_in  = r_dmag_b;
            assign q_in   = '0;
            assign ng_in  = r_neg_b;
            assign ov_in  = r_ovf_b;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign dm_in  = r_dm[s-1];
            assign q_in   = r_q[s-1];
            assign ng_in  = r_ng[s-1];
            assign ov_in  = r_ov[s-1];
        end

        always_comb begin
            trial   = EXT_W'(dm_in) << K;
            ge      = EXT_W'(rem_in) >= trial;
            q_nx    = q_in;
            q_nx[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? (rem_in - trial[MAG_W-1:0]) : rem_in;
                r_dm[s]  <= dm_in;
                r_q[s]   <= q_nx;
                r_ng[s]  <= ng_in;
                r_ov[s]  <= ov_in;
            end
        end
    end

    // sign restore and clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ov[STEPS-1]) begin
                r_out <= r_ng[STEPS-1] ? NEG_MAX : POS_MAX;
                r_sat <= 1'b1;
            end else if (r_ng[STEPS-1]) begin
                if (r_q[STEPS-1] > NEG_MAX) begin
                    r_out <= NEG_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_out <= -r_q[STEPS-1];
                    r_sat <= 1'b0;
                end
            end else begin
                if (r_q[STEPS-1] > POS_MAX) begin
                    r_out <= POS_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_out <= r_q[STEPS-1];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_q   = r_out;
    assign o_sat = r_sat;

endmodule

`default_nettype wire
